// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DataW = 32;
  localparam int PrioW = 8;
  localparam int FillW = 4;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [PrioW-1:0] prio_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic  enq;
    logic  deq;
    data_t data;
    prio_t prio;
  } cell_ctrl_t;

endpackage

// ----- hdl/spq_if.sv -----
`timescale 1ns / 1ps

interface spq_in_if import spq_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    action;
  data_t   item_data;
  prio_t   item_priority;

  modport source (output valid, action, item_data, item_priority, input ready);
  modport sink (input valid, action, item_data, item_priority, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             head_valid;
  data_t            head_data;
  prio_t            head_priority;
  logic [1:0]       status;
  logic [FillW-1:0] fill_level;

  modport source (output valid, head_valid, head_data, head_priority, status, fill_level,
                  input ready);
  modport sink (input valid, head_valid, head_data, head_priority, status, fill_level,
                output ready);
endinterface

// ----- hdl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       prev_ahead,
  input  data_t      prev_data,
  input  prio_t      prev_prio,
  input  data_t      next_data,
  input  prio_t      next_prio,
  output logic       ahead,
  output data_t      data,
  output prio_t      prio
);

  data_t data_next;
  prio_t prio_next;

  // entry stays ahead of an incoming one only if strictly higher priority
  assign ahead = occupied && (ctrl.prio < prio);

  always_comb begin
    data_next = data;
    prio_next = prio;
    if (ctrl.deq) begin
      data_next = next_data;
      prio_next = next_prio;
    end else if (ctrl.enq && !ahead) begin
      if (prev_ahead) begin
        data_next = ctrl.data;
        prio_next = ctrl.prio;
      end else begin
        data_next = prev_data;
        prio_next = prev_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule

// ----- hdl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// An accepted item's result is registered and shows on rsp in the cycle after acceptance.
// Throughput: one item per cycle while no result waits on rsp; the whole row of cells shifts at once.
// req.ready is low only while a result waits on rsp and rsp.ready is low.
// Reset clears the entry count and the result valid flag; slot contents
// and result payload are not cleared and are never read before written.

module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 8
) (
  input logic        clk,
  input logic        rst,
  spq_in_if.sink     req,
  spq_out_if.source  rsp
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            accept;
  logic            full;
  logic            empty;
  cell_ctrl_t      ctrl;

  data_t             cell_data  [DEPTH];
  prio_t             cell_prio  [DEPTH];
  logic [DEPTH-1:0]  cell_ahead;

  logic             res_head_valid;
  data_t            res_head_data;
  prio_t            res_head_priority;
  status_t          res_status;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CntW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    ctrl.enq  = accept && (req.action == ACT_ENQ) && !full;
    ctrl.deq  = accept && (req.action == ACT_DEQ) && !empty;
    ctrl.data = req.item_data;
    ctrl.prio = req.item_priority;
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic  occ;
      logic  p_ahead;
      data_t p_data;
      prio_t p_prio;
      data_t n_data;
      prio_t n_prio;

      assign occ = (CntW'(i) < count);

      if (i == 0) begin : g_first
        assign p_ahead = 1'b1;
        assign p_data  = req.item_data;
        assign p_prio  = req.item_priority;
      end else begin : g_mid
        assign p_ahead = cell_ahead[i-1];
        assign p_data  = cell_data[i-1];
        assign p_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign n_data = cell_data[i];
        assign n_prio = cell_prio[i];
      end else begin : g_inner
        assign n_data = cell_data[i+1];
        assign n_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ),
        .prev_ahead (p_ahead),
        .prev_data  (p_data),
        .prev_prio  (p_prio),
        .next_data  (n_data),
        .next_prio  (n_prio),
        .ahead      (cell_ahead[i]),
        .data       (cell_data[i]),
        .prio       (cell_prio[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CntW'(1);
    end else if (ctrl.deq) begin
      count_next = count - CntW'(1);
    end
  end

  always_comb begin
    res_head_valid    = ctrl.deq;
    res_head_data     = ctrl.deq ? cell_data[0] : '0;
    res_head_priority = ctrl.deq ? cell_prio[0] : '0;
    res_status        = ST_DONE;
    if (req.action == ACT_ENQ && full) begin
      res_status = ST_FULL;
    end else if (req.action == ACT_DEQ && empty) begin
      res_status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.head_valid    <= res_head_valid;
      rsp.head_data     <= res_head_data;
      rsp.head_priority <= res_head_priority;
      rsp.status        <= res_status;
      rsp.fill_level    <= FillW'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == ACT_ENQ && full |=> rsp.status == ST_FULL && $stable(count))
    else $error("enqueue on full not refused");

  a_deq_pops: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == ACT_DEQ && !empty
    |=> rsp.head_valid && count == $past(count) - CntW'(1))
    else $error("dequeue did not remove head");

  a_head_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.head_valid |-> rsp.status == ST_DONE)
    else $error("head returned with error status");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == ACT_ENQ && !full
    |=> count == $past(count) + CntW'(1) && !rsp.head_valid)
    else $error("enqueue did not add entry");

endmodule
